>>> rtl/prt_pkg.sv
// prt_pkg: shared types and constants of the peer registry table
// depends on nothing; used by the channel interfaces and every rtl module
package prt_pkg;

    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int SLOT_W    = 8;
    // span that a filled or cleared slot keeps below the top slot before the limit moves
    localparam int HEAD_SPAN = 5;

    typedef enum logic [1:0] {
        ACT_QUERY      = 2'd0,
        ACT_REGISTER   = 2'd1,
        ACT_DEREGISTER = 2'd2,
        ACT_INVALID    = 2'd3
    } t_action;

    // one stored table entry
    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] ip_addr;
        logic [PORT_W-1:0] port_num;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_result;

endpackage

>>> rtl/prt_if.sv
// prt_if: valid/ready channel interfaces for request and response beats
// depends on prt_pkg
interface prt_req_if import prt_pkg::*; ();
    logic              valid;
    logic              ready;
    t_action           action;
    logic [ADDR_W-1:0] ip_addr;
    logic [PORT_W-1:0] port_num;

    modport source (output valid, action, ip_addr, port_num, input ready);
    modport sink   (input valid, action, ip_addr, port_num, output ready);
endinterface

interface prt_rsp_if import prt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, found, slot, input ready);
    modport sink   (input valid, found, slot, output ready);
endinterface

>>> rtl/prt_entry_ram.sv
// prt_entry_ram: single-port-write, registered-read entry memory
// depends on prt_pkg (t_entry)
module prt_entry_ram
    import prt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data
);

    t_entry mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/prt_ctrl.sv
// prt_ctrl: sequencer that clears the table, scans it per request and writes back
// depends on prt_pkg and prt_req_if; drives the ports of prt_entry_ram
module prt_ctrl
    import prt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    prt_req_if.sink          i_req,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_entry           i_rd_data,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_entry           o_wr_data,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    localparam int LIM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [LIM_W-1:0] TOP_SLOT = LIM_W'(TABLE_DEPTH - 1);
    localparam logic [LIM_W-1:0] SPAN     = LIM_W'(HEAD_SPAN);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_iss, n_iss;
    logic              r_dv, n_dv;
    logic [IDX_W-1:0]  r_chk, n_chk;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic              r_free, n_free;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic              r_last_used, n_last_used;
    logic [LIM_W-1:0]  r_limit, n_limit;
    t_action           r_action;
    logic [ADDR_W-1:0] r_ip;
    logic [PORT_W-1:0] r_port;

    logic [IDX_W-1:0] last_scan;
    logic             match_now;
    logic [LIM_W-1:0] hit_ext;
    logic [LIM_W-1:0] free_ext;
    logic             grow_ok;
    logic             shrink_ok;
    logic             accept;

    assign accept    = i_req.valid && (r_state == ST_IDLE);
    assign last_scan = IDX_W'(r_limit - LIM_W'(1));
    assign match_now = i_rd_data.used && (i_rd_data.ip_addr == r_ip)
                       && (i_rd_data.port_num == r_port);
    assign hit_ext   = {1'b0, r_hit_idx};
    assign free_ext  = {1'b0, r_free_idx};

    // limit moves only at its edge, slot plus span below the reserved top slot
    assign grow_ok   = (LIM_W'(free_ext + LIM_W'(1)) == r_limit)
                       && (LIM_W'(free_ext + SPAN) < TOP_SLOT);
    assign shrink_ok = (LIM_W'(hit_ext + LIM_W'(2)) == r_limit) && !r_last_used
                       && (LIM_W'(hit_ext + SPAN) < TOP_SLOT);

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rd_addr   = r_idx;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_iss       = r_iss;
        n_dv        = 1'b0;
        n_chk       = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_last_used = r_last_used;
        n_limit     = r_limit;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_idx;
        o_wr_data   = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            ST_CLEAR: begin
                // sweep every entry to unused after reset
                o_wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_hit       = 1'b0;
                    n_free      = 1'b0;
                    n_last_used = 1'b0;
                    n_idx       = '0;
                    if (i_req.action == ACT_INVALID) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_iss   = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue reads of slots below the limit
                n_dv = r_iss;
                if (r_iss) begin
                    if (r_idx == last_scan) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                // check the entry read in the previous cycle
                if (r_dv) begin
                    if (match_now && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_chk;
                    end
                    if (!i_rd_data.used && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_chk;
                    end
                    if (r_chk == last_scan) begin
                        n_last_used = i_rd_data.used;
                        n_idx       = '0;
                        n_state     = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // result beat and write-back leave together
                o_res_valid = 1'b1;
                unique case (r_action)
                    ACT_QUERY: begin
                        o_res.found = r_hit;
                        o_res.slot  = r_hit ? SLOT_W'({{SLOT_W{1'b0}}, r_hit_idx}) : '0;
                    end
                    ACT_REGISTER: begin
                        priority if (r_hit) begin
                            o_res.found = 1'b1;
                            o_res.slot  = SLOT_W'({{SLOT_W{1'b0}}, r_hit_idx});
                        end else if (r_free) begin
                            o_res.found        = 1'b1;
                            o_res.slot         = SLOT_W'({{SLOT_W{1'b0}}, r_free_idx});
                            o_wr_en            = i_res_ready;
                            o_wr_addr          = r_free_idx;
                            o_wr_data.used     = 1'b1;
                            o_wr_data.ip_addr  = r_ip;
                            o_wr_data.port_num = r_port;
                            if (i_res_ready && grow_ok) begin
                                n_limit = LIM_W'(r_limit + LIM_W'(1));
                            end
                        end else begin
                            o_res = '0;
                        end
                    end
                    ACT_DEREGISTER: begin
                        if (r_hit) begin
                            o_res.found = 1'b1;
                            o_res.slot  = SLOT_W'({{SLOT_W{1'b0}}, r_hit_idx});
                            o_wr_en     = i_res_ready;
                            o_wr_addr   = r_hit_idx;
                            if (i_res_ready && shrink_ok) begin
                                n_limit = LIM_W'(hit_ext + LIM_W'(1));
                            end
                        end
                    end
                    ACT_INVALID: begin
                        o_res = '0;
                    end
                    default: begin
                        o_res = '0;
                    end
                endcase
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_iss       <= 1'b0;
            r_dv        <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_last_used <= 1'b0;
            r_limit     <= LIM_W'(1);
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_iss       <= n_iss;
            r_dv        <= n_dv;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_last_used <= n_last_used;
            r_limit     <= n_limit;
        end
    end

    // scan bookkeeping and request payload
    always_ff @(posedge i_clk) begin
        r_chk      <= n_chk;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (accept) begin
            r_action <= i_req.action;
            r_ip     <= i_req.ip_addr;
            r_port   <= i_req.port_num;
        end
    end

endmodule

>>> rtl/peer_registry_table.sv
// peer_registry_table: top level, entry memory, sequencer and response register
// depends on prt_pkg, prt_if, prt_entry_ram and prt_ctrl
//
//  channel | dir | beat fields                 | handshake
//  i_req   | in  | action, ip_addr, port_num   | valid / ready
//  o_rsp   | out | found, slot                 | valid / ready
//
// after reset the sequencer sweeps all TABLE_DEPTH entries to unused, one per
// cycle; no request is taken during that sweep
// each request scans the slots below the current limit, reading one entry a
// cycle from the single read port of the entry memory; an invalid action skips the scan
// a request is accepted only while the sequencer is idle; a finished response
// sits in the output register while the next request is scanned, and write-back
// waits until that register is free
module peer_registry_table
    import prt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    prt_req_if.sink  i_req,
    prt_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             res_valid;
    t_result          res;
    logic             res_ready;

    logic    r_rsp_valid;
    t_result r_rsp;

    prt_entry_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    prt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register is free when empty or being drained
    assign res_ready = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res_ready) begin
            r_rsp_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_rsp <= res;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.found = r_rsp.found;
    assign o_rsp.slot  = r_rsp.slot;

endmodule

>>> bench/peer_registry_table_test.sv
`timescale 1ns / 1ps
// peer_registry_table_test: self-checking bench for the peer registry table
// depends on prt_pkg, prt_if and peer_registry_table from the rtl folder
module peer_registry_table_test
    import prt_pkg::*;
();

    localparam int TABLE_DEPTH    = 256;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int TAIL_CYCLES    = 600;
    localparam int MAX_REPORTS    = 200;

    // one row of the directed stimulus table
    typedef struct {
        t_action           act;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        bit                known;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    prt_req_if req_ch ();
    prt_rsp_if rsp_ch ();

    peer_registry_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // predicted table contents and scan reach
    logic              peer_used [TABLE_DEPTH];
    logic [ADDR_W-1:0] peer_addr [TABLE_DEPTH];
    logic [PORT_W-1:0] peer_port [TABLE_DEPTH];
    logic [8:0]        peer_reach;

    t_result   slot_replies_q [$];
    t_stim_row directed_rows [0:24];
    logic [ADDR_W-1:0] pool_addr [32];
    logic [PORT_W-1:0] pool_port [32];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------- predictor

    // slots at or past the reserved top slot never count as free
    function automatic bit slot_open(input int s);
        if (s >= TABLE_DEPTH - 1)
            return 1'b0;
        return !peer_used[s];
    endfunction

    function automatic int search_span();
        return (int'(peer_reach) < TABLE_DEPTH) ? int'(peer_reach) : TABLE_DEPTH;
    endfunction

    function automatic bit find_peer(input logic [ADDR_W-1:0] a,
                                     input logic [PORT_W-1:0] p, output int hit);
        int lim;
        int s;
        lim = search_span();
        hit = 0;
        for (s = 0; s < lim; s++) begin
            if (peer_used[s] && peer_addr[s] == a && peer_port[s] == p) begin
                hit = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // applies one request beat to the predicted table, returns the reply
    function automatic t_result resolve_request(input t_action act,
                                                input logic [ADDR_W-1:0] a,
                                                input logic [PORT_W-1:0] p);
        t_result r;
        int hit;
        int lim;
        int s;
        bit ok;
        ok  = 1'b0;
        hit = 0;
        case (act)
            ACT_QUERY: begin
                ok = find_peer(a, p, hit);
            end
            ACT_REGISTER: begin
                ok = find_peer(a, p, hit);
                lim = search_span();
                // first free slot under the reach, grow when it was the last one
                for (s = 0; s < lim && !ok; s++) begin
                    if (!peer_used[s]) begin
                        peer_used[s] = 1'b1;
                        peer_addr[s] = a;
                        peer_port[s] = p;
                        if (s + 1 == int'(peer_reach) && slot_open(s + 2) &&
                            slot_open(s + 3) && slot_open(s + 4) && slot_open(s + 5))
                            peer_reach = peer_reach + 9'd1;
                        hit = s;
                        ok  = 1'b1;
                    end
                end
            end
            ACT_DEREGISTER: begin
                ok = find_peer(a, p, hit);
                if (ok) begin
                    peer_used[hit] = 1'b0;
                    peer_addr[hit] = '0;
                    peer_port[hit] = '0;
                    // pull the reach back when the freed slot sat next to the last slot under it
                    if (hit + 2 == int'(peer_reach) && slot_open(hit + 1) &&
                        slot_open(hit + 3) && slot_open(hit + 4) && slot_open(hit + 5))
                        peer_reach = 9'(hit + 1);
                end
            end
            default: begin
            end
        endcase
        r.found = ok;
        r.slot  = ok ? SLOT_W'(hit) : '0;
        return r;
    endfunction

    // ---------------------------------------------------------------- request side

    task automatic send_beat(input t_action act, input logic [ADDR_W-1:0] a,
                             input logic [PORT_W-1:0] p, input bit known,
                             input t_result typed, output bit ok);
        t_result predicted;
        // random gap before the beat
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.ip_addr  <= a;
        req_ch.port_num <= p;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        predicted = resolve_request(act, a, p);
        slot_replies_q.push_back(known ? typed : predicted);
        ok = predicted.found;
    endtask

    // hold the request side until every reply is back
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (slot_replies_q.size() != 0)
            @(posedge i_clk);
    endtask

    // pool-based traffic with some cross-paired ports and raw noise beats
    task automatic run_mixed(input int count, input int pool_n);
        int r;
        int ai;
        int pi;
        t_action act;
        bit ok;
        repeat (count) begin
            r  = $urandom_range(99);
            ai = $urandom_range(pool_n - 1);
            pi = ($urandom_range(9) == 0) ? $urandom_range(pool_n - 1) : ai;
            if (r < 40)
                act = ACT_REGISTER;
            else if (r < 65)
                act = ACT_QUERY;
            else if (r < 92)
                act = ACT_DEREGISTER;
            else
                act = ACT_INVALID;
            if ($urandom_range(19) == 0)
                send_beat(t_action'($urandom_range(3)), $urandom, PORT_W'($urandom),
                          1'b0, '0, ok);
            else
                send_beat(act, pool_addr[ai], pool_port[pi], 1'b0, '0, ok);
        end
    endtask

    // ---------------------------------------------------------------- reply side

    // ready pattern, with a long hold-off counted here when requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_req     <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each reply beat with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (slot_replies_q.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: reply with none pending, got found=%0b slot=%0d",
                             $time, rsp_ch.found, rsp_ch.slot);
            end else begin
                want = slot_replies_q.pop_front();
                if (rsp_ch.found !== want.found || rsp_ch.slot !== want.slot) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: expected found=%0b slot=%0d, got found=%0b slot=%0d",
                                 $time, want.found, want.slot, rsp_ch.found, rsp_ch.slot);
                end
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        int s;
        int fails;
        bit ok;
        t_result typed;
        logic [ADDR_W-1:0] a;
        logic [PORT_W-1:0] p;

        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_QUERY;
        req_ch.ip_addr  = '0;
        req_ch.port_num = '0;
        rsp_ch.ready    = 1'b0;

        for (s = 0; s < TABLE_DEPTH; s++) begin
            peer_used[s] = 1'b0;
            peer_addr[s] = '0;
            peer_port[s] = '0;
        end
        peer_reach = 9'd1;
        for (s = 0; s < 32; s++) begin
            pool_addr[s] = $urandom;
            pool_port[s] = PORT_W'($urandom);
        end

        // empty table, extremes, partial matches, hole refill, reach growth and shrink
        directed_rows = '{
            '{ACT_QUERY,      32'h0000_0000, 16'h0000, 1'b1, 1'b0, 8'd0},
            '{ACT_INVALID,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 8'd0},
            '{ACT_REGISTER,   32'h0000_0000, 16'h0000, 1'b1, 1'b1, 8'd0},
            '{ACT_REGISTER,   32'h0000_0000, 16'h0000, 1'b1, 1'b1, 8'd0},
            '{ACT_QUERY,      32'h0000_0000, 16'h0000, 1'b1, 1'b1, 8'd0},
            '{ACT_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'd1},
            '{ACT_QUERY,      32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0, 8'd0},
            '{ACT_QUERY,      32'h0000_0000, 16'hFFFF, 1'b1, 1'b0, 8'd0},
            '{ACT_INVALID,    32'h0000_0000, 16'h0000, 1'b1, 1'b0, 8'd0},
            '{ACT_REGISTER,   32'hA5A5_A5A5, 16'h5A5A, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'd1},
            '{ACT_REGISTER,   32'h1234_5678, 16'h9ABC, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'hA5A5_A5A5, 16'h5A5A, 1'b0, 1'b0, 8'd0},
            '{ACT_QUERY,      32'hA5A5_A5A5, 16'h5A5A, 1'b1, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h1234_5678, 16'h9ABC, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 8'd0},
            '{ACT_REGISTER,   32'h8000_0000, 16'h8000, 1'b0, 1'b0, 8'd0},
            '{ACT_REGISTER,   32'h0000_0001, 16'h0001, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h8000_0000, 16'h8000, 1'b0, 1'b0, 8'd0},
            '{ACT_QUERY,      32'h0000_0001, 16'h0001, 1'b0, 1'b0, 8'd0},
            '{ACT_REGISTER,   32'h7FFF_FFFF, 16'h7FFF, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h0000_0001, 16'h0001, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, 1'b0, 8'd0},
            '{ACT_DEREGISTER, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, 1'b0, 8'd0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, no idling
        for (s = 0; s < 25; s++) begin
            typed.found = directed_rows[s].found;
            typed.slot  = directed_rows[s].slot;
            send_beat(directed_rows[s].act, directed_rows[s].addr, directed_rows[s].port,
                      directed_rows[s].known, typed, ok);
        end

        // mixed traffic, no idling
        run_mixed(250, 24);
        drain_replies();

        // fill the table until registering fails twice, sender idling
        src_idle_pct = 60;
        fails = 0;
        while (fails < 2) begin
            send_beat(ACT_REGISTER, $urandom, PORT_W'($urandom), 1'b0, '0, ok);
            if (!ok)
                fails++;
        end
        repeat (30) begin
            s = $urandom_range(TABLE_DEPTH - 1);
            if (peer_used[s])
                send_beat(ACT_QUERY, peer_addr[s], peer_port[s], 1'b0, '0, ok);
            else
                send_beat(ACT_QUERY, $urandom, PORT_W'($urandom), 1'b0, '0, ok);
        end
        drain_replies();

        // empty it again from the top down so the reach shrinks step by step
        src_idle_pct   = 0;
        sink_stall_pct = 60;
        for (s = TABLE_DEPTH - 1; s >= 0; s--) begin
            if (peer_used[s]) begin
                a = peer_addr[s];
                p = peer_port[s];
                send_beat(ACT_DEREGISTER, a, p, 1'b0, '0, ok);
                if ($urandom_range(7) == 0)
                    send_beat(ACT_QUERY, a, p, 1'b0, '0, ok);
            end
        end
        drain_replies();

        // churn on a small pool, both sides idling, with a long receiver hold-off
        src_idle_pct   = 21;
        sink_stall_pct = 21;
        run_mixed(90, 12);
        hold_req <= 1'b1;
        run_mixed(60, 12);
        drain_replies();
        run_mixed(80, 12);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && slot_replies_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
